[rtl/fixed_point_quantizer_rounding_modes_top_assert.svh]
// assertion macros used by the quantizer top level
`ifndef FIXED_POINT_QUANTIZER_ROUNDING_MODES_TOP_ASSERT_SVH
`define FIXED_POINT_QUANTIZER_ROUNDING_MODES_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FPQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("fpq check failed");

// next-cycle implication, checked outside reset
`define FPQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("fpq check failed");

`endif

[rtl/fpq_pkg.sv]
// types and constants of the fixed-point quantizer
package fpq_pkg;

    localparam int IN_WIDTH  = 48;
    localparam int IN_FRAC   = 24;
    localparam int RND_W     = 7;
    localparam int PROB_W    = 7;
    localparam int INTB_W    = 5;
    localparam int FRACB_W   = 5;
    localparam int EXP_W     = $clog2(IN_WIDTH);
    localparam int PROD_W    = RND_W + IN_FRAC;
    localparam int RND_SCALE = 100;

    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    typedef enum logic [1:0] {
        MODE_STOCHASTIC = 2'd0,
        MODE_NEAREST    = 2'd1,
        MODE_PROB       = 2'd2,
        MODE_TRUNCATE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_INT_BITS     = 2'd0,
        REG_FRAC_BITS    = 2'd1,
        REG_MODE         = 2'd2,
        REG_PROB_PERCENT = 2'd3
    } reg_idx_t;

    localparam logic [INTB_W-1:0]  RST_INT_BITS  = INTB_W'(8);
    localparam logic [FRACB_W-1:0] RST_FRAC_BITS = FRACB_W'(8);
    localparam mode_t              RST_MODE      = MODE_NEAREST;
    localparam logic [PROB_W-1:0]  RST_PROB      = PROB_W'(50);

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] value;
        logic [RND_W-1:0]           random;
        logic                       last;
    } in_word_t;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] quantized;
        logic                       saturated;
        logic                       last_res;
    } out_word_t;

    // settings seen by the datapath, grid values already worked out
    typedef struct packed {
        mode_t                mode;
        logic [PROB_W-1:0]    prob_percent;
        logic [EXP_W-1:0]     step_exp;
        logic [IN_WIDTH-1:0]  lim;
        logic [IN_WIDTH-1:0]  step;
        logic [IN_WIDTH-1:0]  step_mask;
        logic [IN_WIDTH-1:0]  bound_pos;
    } cfg_t;

endpackage

[rtl/fpq_cfg.sv]
// apb register file and grid setup of the quantizer
module fpq_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fpq_pkg::APB_AW-1:0]  paddr,
    input  logic [fpq_pkg::APB_DW-1:0]  pwdata,
    output logic [fpq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output fpq_pkg::cfg_t               cfg
);
    import fpq_pkg::*;

    logic [INTB_W-1:0]  int_bits_reg;
    logic [FRACB_W-1:0] frac_bits_reg;
    mode_t              mode_reg;
    logic [PROB_W-1:0]  prob_reg;
    cfg_t               derived_reg;
    cfg_t               derived_next;
    reg_idx_t           idx;
    logic               wr_en;

    function automatic cfg_t grid_setup(
        input logic [INTB_W-1:0]  ib,
        input logic [FRACB_W-1:0] fb,
        input mode_t              md,
        input logic [PROB_W-1:0]  pp
    );
        logic [EXP_W:0]   e_sum;
        logic [EXP_W-1:0] e;
        logic [EXP_W-1:0] f;
        logic [EXP_W-1:0] s;
        cfg_t             c;
        e_sum = (EXP_W+1)'(ib) + (EXP_W+1)'(IN_FRAC);
        if (e_sum > (EXP_W+1)'(IN_WIDTH - 1))
            e = EXP_W'(IN_WIDTH - 1);
        else
            e = e_sum[EXP_W-1:0];
        if (EXP_W'(fb) > EXP_W'(IN_FRAC))
            f = EXP_W'(IN_FRAC);
        else
            f = EXP_W'(fb);
        s = EXP_W'(IN_FRAC) - f;
        if (s > e)
            s = e;
        c.mode         = md;
        c.prob_percent = pp;
        c.step_exp     = s;
        c.lim          = IN_WIDTH'(1) << e;
        c.step         = IN_WIDTH'(1) << s;
        c.step_mask    = c.step - IN_WIDTH'(1);
        c.bound_pos    = c.lim - c.step;
        return c;
    endfunction

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_bits_reg  <= RST_INT_BITS;
            frac_bits_reg <= RST_FRAC_BITS;
            mode_reg      <= RST_MODE;
            prob_reg      <= RST_PROB;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_INT_BITS:     int_bits_reg  <= pwdata[INTB_W-1:0];
                REG_FRAC_BITS:    frac_bits_reg <= pwdata[FRACB_W-1:0];
                REG_MODE:         mode_reg      <= mode_t'(pwdata[1:0]);
                REG_PROB_PERCENT: prob_reg      <= pwdata[PROB_W-1:0];
                default:          ;
            endcase
        end
    end

    // grid values are registered and follow the registers in the next cycle
    assign derived_next = grid_setup(int_bits_reg, frac_bits_reg, mode_reg, prob_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            derived_reg <= grid_setup(RST_INT_BITS, RST_FRAC_BITS, RST_MODE, RST_PROB);
        else
            derived_reg <= derived_next;
    end

    assign cfg = derived_reg;

    always_comb
    begin
        unique case (idx)
            REG_INT_BITS:     prdata = APB_DW'(int_bits_reg);
            REG_FRAC_BITS:    prdata = APB_DW'(frac_bits_reg);
            REG_MODE:         prdata = APB_DW'(mode_reg);
            REG_PROB_PERCENT: prdata = APB_DW'(prob_reg);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/fixed_point_quantizer_rounding_modes_top.sv]
// top level of the fixed-point quantizer: register port and rounding pipeline
//
//  channel   | direction | handshake                  | word
//  ----------+-----------+----------------------------+--------------------------
//  item      | in        | item_valid / item_ready    | value, random, last
//  result    | out       | result_valid / result_ready| quantized, saturated, last_res
//  apb       | in/out    | psel, penable, pready      | paddr, pwdata, prdata
//
// one word per cycle while result_ready keeps the output stage moving
// five register stages: input, magnitude, rounding decision, step add, sign restore
// each stage moves when the one after it is empty or moving, so stalls back up
// without a bubble; item_ready drops only when every stage holds a word
// reset empties all stages and loads the default settings
`include "fixed_point_quantizer_rounding_modes_top_assert.svh"

module fixed_point_quantizer_rounding_modes_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  fpq_pkg::in_word_t           item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output fpq_pkg::out_word_t          result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fpq_pkg::APB_AW-1:0]  paddr,
    input  logic [fpq_pkg::APB_DW-1:0]  pwdata,
    output logic [fpq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import fpq_pkg::*;

    // stage payloads
    typedef struct packed {
        logic                neg;
        logic [IN_WIDTH-1:0] mag;
        logic [RND_W-1:0]    rnd;
        logic                last;
    } mag_st_t;

    typedef struct packed {
        logic                neg;
        logic                last;
        logic [IN_WIDTH-1:0] trunc;
        logic [IN_WIDTH-1:0] bound;
        logic                up;
        logic                sat;
    } dec_st_t;

    typedef struct packed {
        logic                neg;
        logic                last;
        logic [IN_WIDTH-1:0] res;
        logic [IN_WIDTH-1:0] bound;
        logic                sat;
    } res_st_t;

    cfg_t      cfg;

    logic      v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic      rdy1, rdy2, rdy3, rdy4, rdyo;

    in_word_t  s1_reg;
    mag_st_t   s2_reg, s2_next;
    dec_st_t   s3_reg, s3_next;
    res_st_t   s4_reg, s4_next;
    out_word_t so_reg, so_next;

    logic [IN_FRAC-1:0]  rem;
    logic [PROD_W-1:0]   rem_x100;
    logic [PROD_W-1:0]   rnd_scaled;
    logic [IN_WIDTH:0]   stepped;

    fpq_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stall chain, output side first
    assign rdyo       = !vo_reg || result_ready;
    assign rdy4       = !v4_reg || rdyo;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign item_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= item_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdyo) vo_reg <= v4_reg;
        end
    end

    // magnitude and sign
    always_comb
    begin
        s2_next.neg  = s1_reg.value[IN_WIDTH-1];
        s2_next.mag  = s2_next.neg ? (IN_WIDTH'(0) - IN_WIDTH'(s1_reg.value))
                                   : IN_WIDTH'(s1_reg.value);
        s2_next.rnd  = s1_reg.random;
        s2_next.last = s1_reg.last;
    end

    // leftover below the grid, first clamp and rounding decision
    assign rem        = s2_reg.mag[IN_FRAC-1:0] & cfg.step_mask[IN_FRAC-1:0];
    assign rem_x100   = PROD_W'(rem) * PROD_W'(RND_SCALE);
    assign rnd_scaled = PROD_W'(s2_reg.rnd) << cfg.step_exp;

    always_comb
    begin
        s3_next.neg   = s2_reg.neg;
        s3_next.last  = s2_reg.last;
        s3_next.trunc = s2_reg.mag & ~cfg.step_mask;
        s3_next.bound = s2_reg.neg ? cfg.lim : cfg.bound_pos;
        s3_next.sat   = s2_reg.mag > s3_next.bound;
        case (cfg.mode)
            MODE_STOCHASTIC: s3_next.up = rem_x100 > rnd_scaled;
            MODE_NEAREST:    s3_next.up = ((IN_WIDTH+1)'(rem) << 1) >=
                                          (IN_WIDTH+1)'(cfg.step);
            MODE_PROB:       s3_next.up = (s2_reg.mag != '0) &&
                                          (cfg.prob_percent > s2_reg.rnd);
            default:         s3_next.up = 1'b0;
        endcase
    end

    // step away from zero and second clamp
    assign stepped = (IN_WIDTH+1)'(s3_reg.trunc) +
                     (s3_reg.up ? (IN_WIDTH+1)'(cfg.step) : (IN_WIDTH+1)'(0));

    always_comb
    begin
        s4_next.neg   = s3_reg.neg;
        s4_next.last  = s3_reg.last;
        s4_next.bound = s3_reg.bound;
        if (s3_reg.sat || (stepped > (IN_WIDTH+1)'(s3_reg.bound)))
        begin
            s4_next.res = s3_reg.bound;
            s4_next.sat = 1'b1;
        end
        else
        begin
            s4_next.res = stepped[IN_WIDTH-1:0];
            s4_next.sat = 1'b0;
        end
    end

    // sign restore
    always_comb
    begin
        so_next.quantized = s4_reg.neg ? $signed(IN_WIDTH'(0) - s4_reg.res)
                                       : $signed(s4_reg.res);
        so_next.saturated = s4_reg.sat;
        so_next.last_res  = s4_reg.last;
    end

    // payload registers, loaded whenever the stage may move
    always_ff @(posedge clk)
    begin
        if (rdy1) s1_reg <= item;
        if (rdy2) s2_reg <= s2_next;
        if (rdy3) s3_reg <= s3_next;
        if (rdy4) s4_reg <= s4_next;
        if (rdyo) so_reg <= so_next;
    end

    assign result_valid = vo_reg;
    assign result       = so_reg;

    // checks
    `FPQ_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !vo_reg, item_ready)
    `FPQ_ASSERT_IMP(a_truncate_never_moves, clk, rst_n,
        v3_reg && (cfg.mode == MODE_TRUNCATE), !s3_reg.up)
    `FPQ_ASSERT_IMP(a_res_within_bound, clk, rst_n, v4_reg, s4_reg.res <= s4_reg.bound)
    `FPQ_ASSERT_IMP(a_result_on_grid, clk, rst_n, vo_reg,
        (IN_WIDTH'(so_reg.quantized) & cfg.step_mask) == '0)
    `FPQ_ASSERT_NXT(a_stall_keeps_word, clk, rst_n, vo_reg && !result_ready,
        vo_reg && (so_reg == $past(so_reg)))

endmodule
